// File: src/cau_pkg.sv
package cau_pkg;

   // Default word format, Q16.16
   localparam int DEF_WORD_BITS = 32;
   localparam int DEF_FRAC_BITS = 16;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Operation codes on the request side
   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_IDIV = 3'd4,
      CMD_NEG  = 3'd5,
      CMD_GT   = 3'd6,
      CMD_LT   = 3'd7
   } cmd_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   // How the back end finishes an item
   typedef enum logic [2:0] {
      KIND_PASS,
      KIND_MUL,
      KIND_CDIV,
      KIND_IDIV,
      KIND_ZDIV,
      KIND_ORDER
   } kind_type;

   // Classification handed from front to back
   typedef struct packed {
      kind_type kind;
      logic     dneg;
      logic     order;
   } ctl_type;

endpackage

// File: src/cau_fifo.sv
module cau_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: src/cau_front.sv
module cau_front #(
   parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [2:0]                    req_cmd,
   input  logic signed [WORD_BITS-1:0]   req_a_re,
   input  logic signed [WORD_BITS-1:0]   req_a_im,
   input  logic signed [WORD_BITS-1:0]   req_b_re,
   input  logic signed [WORD_BITS-1:0]   req_b_im,
   input  logic signed [WORD_BITS-1:0]   req_int_divisor,
   output logic                          q_push,
   input  logic                          q_full,
   output logic signed [2*WORD_BITS:0]   q_re,
   output logic signed [2*WORD_BITS:0]   q_im,
   output logic [2*WORD_BITS-1:0]        q_den,
   output cau_pkg::ctl_type              q_ctl
);

   localparam int W  = WORD_BITS;
   localparam int W1 = W + 1;
   localparam int P  = 2 * W;
   localparam int S  = P + 1;

   // Angle classes, ordered as the angle grows
   localparam logic [1:0] ANG_LOW      = 2'd0;
   localparam logic [1:0] ANG_MID      = 2'd1;
   localparam logic [1:0] ANG_NEG_REAL = 2'd2;

   function automatic logic [1:0] angle_class(logic signed [W-1:0] re,
                                              logic signed [W-1:0] im);
      logic [1:0] cls;
      if (im < 0) cls = ANG_LOW;
      else if (im == 0 && re < 0) cls = ANG_NEG_REAL;
      else cls = ANG_MID;
      return cls;
   endfunction

   logic en;

   // Stage 1: products and short sums
   logic              f1_valid_ff, f1_valid_in;
   cau_pkg::cmd_type  f1_cmd_ff;
   logic signed [P-1:0] f1_arbr_ff, f1_aibi_ff, f1_aibr_ff, f1_arbi_ff;
   logic signed [P-1:0] f1_brbr_ff, f1_bibi_ff, f1_arar_ff, f1_aiai_ff;
   logic signed [W1-1:0] f1_s_re_ff, f1_s_im_ff, f1_s_re_in, f1_s_im_in;
   logic signed [W-1:0] f1_a_re_ff, f1_a_im_ff;
   logic [W-1:0]        f1_d_mag_ff, f1_d_mag_in;
   logic                f1_d_neg_ff, f1_d_zero_ff;
   logic [1:0]          f1_ca_ff, f1_cb_ff;

   // Stage 2: classified item
   logic                f2_valid_ff, f2_valid_in;
   logic signed [S-1:0] f2_re_ff, f2_im_ff, f2_re_in, f2_im_in;
   logic [P-1:0]        f2_den_ff, f2_den_in;
   cau_pkg::ctl_type    f2_ctl_ff, f2_ctl_in;

   logic [P-1:0] mag_a, mag_b, den_c;
   logic         same_cls, a_above, a_below, a_gt, a_lt;

   assign en       = !(f2_valid_ff && q_full);
   assign req_full = !en;
   assign q_push   = f2_valid_ff && !q_full;
   assign q_re     = f2_re_ff;
   assign q_im     = f2_im_ff;
   assign q_den    = f2_den_ff;
   assign q_ctl    = f2_ctl_ff;

   // Form add, subtract and negate sums and the divisor magnitude
   always_comb begin
      case (req_cmd)
         cau_pkg::CMD_SUB: begin
            f1_s_re_in = W1'(req_a_re) - W1'(req_b_re);
            f1_s_im_in = W1'(req_a_im) - W1'(req_b_im);
         end
         cau_pkg::CMD_NEG: begin
            f1_s_re_in = -W1'(req_a_re);
            f1_s_im_in = -W1'(req_a_im);
         end
         default: begin
            f1_s_re_in = W1'(req_a_re) + W1'(req_b_re);
            f1_s_im_in = W1'(req_a_im) + W1'(req_b_im);
         end
      endcase
      f1_d_mag_in = req_int_divisor[W-1] ? (~req_int_divisor + 1'b1) : req_int_divisor;
   end

   assign f1_valid_in = en ? req_push : f1_valid_ff;
   assign f2_valid_in = en ? f1_valid_ff : f2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   // Load stage 1
   always_ff @(posedge clock) begin
      if (en) begin
         f1_cmd_ff    <= cau_pkg::cmd_type'(req_cmd);
         f1_arbr_ff   <= P'(req_a_re) * P'(req_b_re);
         f1_aibi_ff   <= P'(req_a_im) * P'(req_b_im);
         f1_aibr_ff   <= P'(req_a_im) * P'(req_b_re);
         f1_arbi_ff   <= P'(req_a_re) * P'(req_b_im);
         f1_brbr_ff   <= P'(req_b_re) * P'(req_b_re);
         f1_bibi_ff   <= P'(req_b_im) * P'(req_b_im);
         f1_arar_ff   <= P'(req_a_re) * P'(req_a_re);
         f1_aiai_ff   <= P'(req_a_im) * P'(req_a_im);
         f1_s_re_ff   <= f1_s_re_in;
         f1_s_im_ff   <= f1_s_im_in;
         f1_a_re_ff   <= req_a_re;
         f1_a_im_ff   <= req_a_im;
         f1_d_mag_ff  <= f1_d_mag_in;
         f1_d_neg_ff  <= req_int_divisor[W-1];
         f1_d_zero_ff <= (req_int_divisor == '0);
         f1_ca_ff     <= angle_class(req_a_re, req_a_im);
         f1_cb_ff     <= angle_class(req_b_re, req_b_im);
      end
   end

   // Squared magnitudes and angle order
   always_comb begin
      mag_a    = $unsigned(f1_arar_ff) + $unsigned(f1_aiai_ff);
      mag_b    = $unsigned(f1_brbr_ff) + $unsigned(f1_bibi_ff);
      den_c    = mag_b;
      same_cls = (f1_ca_ff == f1_cb_ff) && (f1_ca_ff != ANG_NEG_REAL);
      a_above  = (f1_ca_ff > f1_cb_ff) || (same_cls && (f1_arbi_ff < f1_aibr_ff));
      a_below  = (f1_ca_ff < f1_cb_ff) || (same_cls && (f1_arbi_ff > f1_aibr_ff));
      a_gt     = (mag_a > mag_b) || ((mag_a == mag_b) && a_above);
      a_lt     = (mag_a < mag_b) || ((mag_a == mag_b) && a_below);
   end

   // Classify the item for the back end
   always_comb begin
      f2_re_in        = S'(f1_s_re_ff);
      f2_im_in        = S'(f1_s_im_ff);
      f2_den_in       = den_c;
      f2_ctl_in.kind  = cau_pkg::KIND_PASS;
      f2_ctl_in.dneg  = f1_d_neg_ff;
      f2_ctl_in.order = 1'b0;
      unique case (f1_cmd_ff) inside
         cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_NEG: begin
            f2_ctl_in.kind = cau_pkg::KIND_PASS;
         end
         cau_pkg::CMD_MUL: begin
            f2_ctl_in.kind = cau_pkg::KIND_MUL;
            f2_re_in       = S'(f1_arbr_ff) - S'(f1_aibi_ff);
            f2_im_in       = S'(f1_aibr_ff) + S'(f1_arbi_ff);
         end
         cau_pkg::CMD_DIV: begin
            f2_ctl_in.kind = (den_c == '0) ? cau_pkg::KIND_ZDIV : cau_pkg::KIND_CDIV;
            f2_re_in       = S'(f1_arbr_ff) + S'(f1_aibi_ff);
            f2_im_in       = S'(f1_aibr_ff) - S'(f1_arbi_ff);
         end
         cau_pkg::CMD_IDIV: begin
            f2_ctl_in.kind = f1_d_zero_ff ? cau_pkg::KIND_ZDIV : cau_pkg::KIND_IDIV;
            f2_re_in       = S'(f1_a_re_ff);
            f2_im_in       = S'(f1_a_im_ff);
            f2_den_in      = P'(f1_d_mag_ff);
         end
         cau_pkg::CMD_GT, cau_pkg::CMD_LT: begin
            f2_ctl_in.kind  = cau_pkg::KIND_ORDER;
            f2_ctl_in.order = (f1_cmd_ff == cau_pkg::CMD_GT) ? a_gt : a_lt;
         end
         default: begin
            f2_ctl_in.kind = cau_pkg::KIND_PASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_re_ff  <= f2_re_in;
         f2_im_ff  <= f2_im_in;
         f2_den_ff <= f2_den_in;
         f2_ctl_ff <= f2_ctl_in;
      end
   end

endmodule

// File: src/cau_div_lane.sv
module cau_div_lane #(
   parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [2*WORD_BITS+FRAC_BITS-1:0]    in_n,
   input  logic [2*WORD_BITS-1:0]              in_den,
   input  logic                                in_neg,
   input  logic                                in_div,
   output logic [2*WORD_BITS-1:0]              out_mag,
   output logic                                out_neg,
   output logic                                out_ovf
);

   localparam int W = WORD_BITS;
   localparam int P = 2 * W;
   localparam int N = P + FRAC_BITS;
   localparam int R = P + 1;

   logic [R-1:0] rem_ff [W+1];
   logic [P-1:0] n_ff   [W+1];
   logic [P-1:0] den_ff [W+1];
   logic [W-1:0] q_ff   [W+1];
   logic         neg_ff [W+1];
   logic         div_ff [W+1];
   logic         ovf_ff [W+1];

   // Start: quotient must fit the word, else flag overflow
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= R'(in_n[N-1:W]);
         n_ff[0]   <= in_n[P-1:0];
         den_ff[0] <= in_den;
         q_ff[0]   <= '0;
         neg_ff[0] <= in_neg;
         div_ff[0] <= in_div;
         ovf_ff[0] <= in_div && (R'(in_n[N-1:W]) >= R'(in_den));
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 1; k <= W; k++) begin : g_step
      logic [R-1:0] trial;
      logic         ge;
      logic [W-1:0] q_in;

      always_comb begin
         trial = {rem_ff[k-1][R-2:0], n_ff[k-1][W-k]};
         ge    = (trial >= R'(den_ff[k-1]));
         q_in  = q_ff[k-1];
         q_in[W-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? (trial - R'(den_ff[k-1])) : trial;
            n_ff[k]   <= n_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in;
            neg_ff[k] <= neg_ff[k-1];
            div_ff[k] <= div_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign out_mag = div_ff[W] ? P'(q_ff[W]) : n_ff[W];
   assign out_neg = neg_ff[W];
   assign out_ovf = ovf_ff[W];

endmodule

// File: src/cau_back.sv
module cau_back #(
   parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic signed [2*WORD_BITS:0]   q_re,
   input  logic signed [2*WORD_BITS:0]   q_im,
   input  logic [2*WORD_BITS-1:0]        q_den,
   input  cau_pkg::ctl_type              q_ctl,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [WORD_BITS-1:0]   rsp_res_re,
   output logic signed [WORD_BITS-1:0]   rsp_res_im,
   output logic                          rsp_order_true,
   output logic [1:0]                    rsp_status
);

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int P = 2 * W;
   localparam int S = P + 1;
   localparam int N = P + F;

   logic en;

   // Sign and magnitude, then scale for the operation
   function automatic logic [N-1:0] prep_n(logic [S-1:0] v, cau_pkg::kind_type kind);
      logic [S-1:0] v_abs;
      logic [P-1:0] mag;
      logic [N-1:0] n;
      v_abs = v[S-1] ? (~v + 1'b1) : v;
      mag   = v_abs[P-1:0];
      case (kind)
         cau_pkg::KIND_MUL:  n = N'(mag >> F);
         cau_pkg::KIND_CDIV: n = {mag, {F{1'b0}}};
         default:            n = N'(mag);
      endcase
      return n;
   endfunction

   // Clamp a magnitude to the word and apply the sign
   function automatic logic [W:0] pack(logic [P-1:0] mag, logic neg, logic ovf);
      logic [P-1:0] lim, cap, val;
      logic         sat;
      logic [W-1:0] word;
      lim  = P'(1) << (W - 1);
      cap  = neg ? lim : lim - 1'b1;
      sat  = ovf || (mag > cap);
      val  = sat ? cap : mag;
      word = neg ? (~val[W-1:0] + 1'b1) : val[W-1:0];
      return {sat, word};
   endfunction

   // Prep stage
   logic             b0_valid_ff;
   cau_pkg::ctl_type b0_ctl_ff;
   logic [N-1:0]     b0_n_re_ff, b0_n_im_ff;
   logic             b0_neg_re_ff, b0_neg_im_ff, b0_div_ff;
   logic [P-1:0]     b0_den_ff;
   logic             is_idiv;

   // Control line beside the divider stages
   logic             line_valid_ff [W+1];
   cau_pkg::ctl_type line_ctl_ff   [W+1];

   logic [P-1:0] mag_re, mag_im;
   logic         neg_re, neg_im, ovf_re, ovf_im;
   logic [W:0]   pk_re, pk_im;

   // Output register
   logic                out_valid_ff;
   logic signed [W-1:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic                out_ord_ff, out_ord_in;
   logic [1:0]          out_st_ff, out_st_in;

   assign en        = !out_valid_ff || rsp_pop;
   assign q_pop     = en && !q_empty;
   assign is_idiv   = (q_ctl.kind == cau_pkg::KIND_IDIV);
   assign rsp_empty = !out_valid_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= W; k++) line_valid_ff[k] <= 1'b0;
      end else if (en) begin
         b0_valid_ff      <= !q_empty;
         line_valid_ff[0] <= b0_valid_ff;
         for (int k = 1; k <= W; k++) line_valid_ff[k] <= line_valid_ff[k-1];
         out_valid_ff     <= line_valid_ff[W];
      end
   end

   // Load prep stage and control line
   always_ff @(posedge clock) begin
      if (en) begin
         b0_ctl_ff    <= q_ctl;
         b0_n_re_ff   <= prep_n(q_re, q_ctl.kind);
         b0_n_im_ff   <= prep_n(q_im, q_ctl.kind);
         b0_neg_re_ff <= q_re[S-1] ^ (is_idiv && q_ctl.dneg);
         b0_neg_im_ff <= q_im[S-1] ^ (is_idiv && q_ctl.dneg);
         b0_div_ff    <= is_idiv || (q_ctl.kind == cau_pkg::KIND_CDIV);
         b0_den_ff    <= q_den;
         line_ctl_ff[0] <= b0_ctl_ff;
         for (int k = 1; k <= W; k++) line_ctl_ff[k] <= line_ctl_ff[k-1];
      end
   end

   cau_div_lane #(.WORD_BITS(W), .FRAC_BITS(F)) u_lane_re (
      .clock   (clock),
      .en      (en),
      .in_n    (b0_n_re_ff),
      .in_den  (b0_den_ff),
      .in_neg  (b0_neg_re_ff),
      .in_div  (b0_div_ff),
      .out_mag (mag_re),
      .out_neg (neg_re),
      .out_ovf (ovf_re)
   );

   cau_div_lane #(.WORD_BITS(W), .FRAC_BITS(F)) u_lane_im (
      .clock   (clock),
      .en      (en),
      .in_n    (b0_n_im_ff),
      .in_den  (b0_den_ff),
      .in_neg  (b0_neg_im_ff),
      .in_div  (b0_div_ff),
      .out_mag (mag_im),
      .out_neg (neg_im),
      .out_ovf (ovf_im)
   );

   // Finish the result
   always_comb begin
      pk_re      = pack(mag_re, neg_re, ovf_re);
      pk_im      = pack(mag_im, neg_im, ovf_im);
      out_re_in  = $signed(pk_re[W-1:0]);
      out_im_in  = $signed(pk_im[W-1:0]);
      out_ord_in = 1'b0;
      out_st_in  = (pk_re[W] || pk_im[W]) ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
      case (line_ctl_ff[W].kind)
         cau_pkg::KIND_ZDIV: begin
            out_re_in = '0;
            out_im_in = '0;
            out_st_in = cau_pkg::STATUS_DIV_ZERO;
         end
         cau_pkg::KIND_ORDER: begin
            out_re_in  = '0;
            out_im_in  = '0;
            out_ord_in = line_ctl_ff[W].order;
            out_st_in  = cau_pkg::STATUS_OK;
         end
         default: begin
            out_ord_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_re_ff  <= out_re_in;
         out_im_ff  <= out_im_in;
         out_ord_ff <= out_ord_in;
         out_st_ff  <= out_st_in;
      end
   end

   assign rsp_res_re     = out_re_ff;
   assign rsp_res_im     = out_im_ff;
   assign rsp_order_true = out_ord_ff;
   assign rsp_status     = out_st_ff;

endmodule

// File: src/complex_arithmetic_unit.sv
// The response path runs through the divider pipeline, which retires one quotient bit
// per stage; its depth follows WORD_BITS (Q16.16 by default).
// Throughput: one item per cycle without back-pressure; every operation shares the pipeline.
// Reset: synchronous, active high; clears all valid bits and the queue, so the
// unit comes out of reset empty and ready.
module complex_arithmetic_unit #(
   parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [2:0]                    req_cmd,
   input  logic signed [WORD_BITS-1:0]   req_a_re,
   input  logic signed [WORD_BITS-1:0]   req_a_im,
   input  logic signed [WORD_BITS-1:0]   req_b_re,
   input  logic signed [WORD_BITS-1:0]   req_b_im,
   input  logic signed [WORD_BITS-1:0]   req_int_divisor,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [WORD_BITS-1:0]   rsp_res_re,
   output logic signed [WORD_BITS-1:0]   rsp_res_im,
   output logic                          rsp_order_true,
   output logic [1:0]                    rsp_status
);

   localparam int P     = 2 * WORD_BITS;
   localparam int S     = P + 1;
   localparam int QBITS = 2 * S + P + $bits(cau_pkg::ctl_type);

   logic                f_push, f_full, b_pop, b_empty;
   logic signed [S-1:0] f_re, f_im, b_re, b_im;
   logic [P-1:0]        f_den, b_den;
   cau_pkg::ctl_type    f_ctl, b_ctl;
   logic [QBITS-1:0]    q_wdata, q_rdata;

   cau_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_a_re        (req_a_re),
      .req_a_im        (req_a_im),
      .req_b_re        (req_b_re),
      .req_b_im        (req_b_im),
      .req_int_divisor (req_int_divisor),
      .q_push          (f_push),
      .q_full          (f_full),
      .q_re            (f_re),
      .q_im            (f_im),
      .q_den           (f_den),
      .q_ctl           (f_ctl)
   );

   // Pack and unpack the queued item
   assign q_wdata = {f_re, f_im, f_den, f_ctl};
   assign {b_re, b_im, b_den, b_ctl} = q_rdata;

   cau_fifo #(.WIDTH(QBITS), .DEPTH(cau_pkg::QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (q_wdata),
      .full  (f_full),
      .pop   (b_pop),
      .rdata (q_rdata),
      .empty (b_empty)
   );

   cau_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (b_empty),
      .q_pop          (b_pop),
      .q_re           (b_re),
      .q_im           (b_im),
      .q_den          (b_den),
      .q_ctl          (b_ctl),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_res_re     (rsp_res_re),
      .rsp_res_im     (rsp_res_im),
      .rsp_order_true (rsp_order_true),
      .rsp_status     (rsp_status)
   );

endmodule
